FILE: rtl/core/jsu_pkg.sv
// types, codes and constants shared by the json string unescape block
package jsu_pkg;

    // result status codes
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_CLOSED   = 3'd1;
    localparam logic [2:0] ST_NO_QUOTE = 3'd2;
    localparam logic [2:0] ST_BAD_HEX  = 3'd3;
    localparam logic [2:0] ST_UNTERM   = 3'd4;

    // command kinds passed from front to back
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_RAW  = 2'd1;
    localparam logic [1:0] K_CP   = 2'd2;
    localparam logic [1:0] K_STAT = 2'd3;

    // results one command can expand to
    localparam int unsigned MAX_RES = 7;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_out;

    typedef struct packed {
        logic        flush;
        logic [9:0]  held;
        logic [1:0]  kind;
        logic [20:0] data;
        logic [2:0]  status;
    } t_cmd;

endpackage

FILE: rtl/core/jsu_front.sv
// front end: accepts input bytes, tracks string and escape state, issues commands
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jsu_pkg::t_in  i_in,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_STR  = 2'd1;
    localparam logic [1:0] M_ESC  = 2'd2;
    localparam logic [1:0] M_HEX  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_held, n_held;
    logic        r_hold, n_hold;

    logic        accept;
    logic        err;
    logic [2:0]  err_code;
    logic        go_idle;
    logic [4:0]  hex_d;
    logic [15:0] hex_v;
    logic [7:0]  b;
    logic        eoi;
    t_cmd        cmd;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A;
            8'h74:   r = 8'h09;
            8'h72:   r = 8'h0D;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

    assign b      = i_in.byte_in;
    assign eoi    = i_in.end_of_input;
    assign hex_d  = hex_value(b);
    assign hex_v  = {r_acc[11:0], hex_d[3:0]};
    assign o_ready = !i_full;
    assign accept = i_valid && !i_full;

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_held   = r_held;
        n_hold   = r_hold;
        cmd      = '0;
        cmd.kind = K_NONE;
        err      = 1'b0;
        err_code = ST_DATA;
        go_idle  = 1'b0;
        case (r_mode)
            M_STR: begin
                if (b == CH_QUOTE) begin
                    cmd.flush  = r_hold;
                    cmd.held   = r_held;
                    cmd.kind   = K_STAT;
                    cmd.status = ST_CLOSED;
                    go_idle    = 1'b1;
                end else if (b == CH_BSL) begin
                    n_mode = M_ESC;
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_UNTERM;
                    end
                end else begin
                    cmd.flush = r_hold;
                    cmd.held  = r_held;
                    cmd.kind  = K_RAW;
                    cmd.data  = {13'd0, b};
                    n_hold    = 1'b0;
                    n_held    = '0;
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_UNTERM;
                    end
                end
            end
            M_ESC: begin
                if (b == CH_U) begin
                    n_mode = M_HEX;
                    n_cnt  = '0;
                    n_acc  = '0;
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_BAD_HEX;
                    end
                end else begin
                    cmd.flush = r_hold;
                    cmd.held  = r_held;
                    cmd.kind  = K_RAW;
                    cmd.data  = {13'd0, escape_byte(b)};
                    n_hold    = 1'b0;
                    n_held    = '0;
                    n_mode    = M_STR;
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_UNTERM;
                    end
                end
            end
            M_HEX: begin
                if (!hex_d[4]) begin
                    err      = 1'b1;
                    err_code = ST_BAD_HEX;
                end else if (r_cnt == 2'd3) begin
                    n_cnt  = '0;
                    n_acc  = '0;
                    n_mode = M_STR;
                    if (r_hold && hex_v[15:10] == 6'b110111) begin
                        cmd.kind = K_CP;
                        cmd.data = 21'h10000 + {1'b0, r_held, hex_v[9:0]};
                        n_hold   = 1'b0;
                        n_held   = '0;
                    end else begin
                        cmd.flush = r_hold;
                        cmd.held  = r_held;
                        if (hex_v[15:10] == 6'b110110) begin
                            n_held = hex_v[9:0];
                            n_hold = 1'b1;
                        end else begin
                            cmd.kind = K_CP;
                            cmd.data = {5'd0, hex_v};
                            n_hold   = 1'b0;
                            n_held   = '0;
                        end
                    end
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_UNTERM;
                    end
                end else begin
                    n_acc = hex_v;
                    n_cnt = r_cnt + 2'd1;
                    if (eoi) begin
                        err      = 1'b1;
                        err_code = ST_BAD_HEX;
                    end
                end
            end
            default: begin
                if (b != CH_QUOTE) begin
                    err      = 1'b1;
                    err_code = ST_NO_QUOTE;
                end else if (eoi) begin
                    err      = 1'b1;
                    err_code = ST_UNTERM;
                end else begin
                    n_mode = M_STR;
                    n_cnt  = '0;
                    n_acc  = '0;
                    n_held = '0;
                    n_hold = 1'b0;
                end
            end
        endcase
        // an error drops everything else this byte caused
        if (err) begin
            cmd        = '0;
            cmd.kind   = K_STAT;
            cmd.status = err_code;
            go_idle    = 1'b1;
        end
        if (go_idle) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_acc  = '0;
            n_held = '0;
            n_hold = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.flush || cmd.kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_held <= '0;
            r_hold <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_held <= n_held;
            r_hold <= n_hold;
        end
    end

endmodule

FILE: rtl/core/jsu_queue.sv
// command queue between front and back
module jsu_queue #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_cmd          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/jsu_back.sv
// back end: expands commands into utf-8 result items, one item per cycle while the output is ready
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_enc;

    logic [7:0] r_list [MAX_RES];
    logic [7:0] n_list [MAX_RES];
    logic [2:0] r_cnt, n_cnt;
    logic [2:0] r_idx;
    logic       r_vld;
    logic       r_is_stat;
    logic [2:0] r_stat;
    logic       is_last;
    logic       load;
    logic [2:0] off;
    t_enc       enc_f, enc_m;

    function automatic t_enc utf8(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

    assign enc_f = utf8({5'd0, 6'b110110, i_cmd.held});
    assign enc_m = utf8(i_cmd.data);
    assign off   = i_cmd.flush ? 3'd3 : 3'd0;

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            n_list[i] = '0;
        end
        if (i_cmd.flush) begin
            for (int j = 0; j < 3; j++) begin
                n_list[j] = enc_f.b[j];
            end
        end
        n_cnt = off;
        case (i_cmd.kind)
            K_RAW: begin
                n_list[off] = i_cmd.data[7:0];
                n_cnt       = off + 3'd1;
            end
            K_CP: begin
                for (int j = 0; j < 4; j++) begin
                    if (3'(j) < enc_m.n) begin
                        n_list[off + 3'(j)] = enc_m.b[j];
                    end
                end
                n_cnt = off + enc_m.n;
            end
            K_STAT: begin
                n_cnt = off + 3'd1;
            end
            default: begin
                n_cnt = off;
            end
        endcase
    end

    assign is_last = (r_idx == r_cnt - 3'd1);
    assign load    = !r_vld || (i_ready && is_last);
    assign o_pop   = load && !i_empty;

    assign o_valid        = r_vld;
    assign o_out.out_byte = r_list[r_idx];
    assign o_out.status   = (is_last && r_is_stat) ? r_stat : ST_DATA;
    assign o_out.last     = is_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_list    <= n_list;
            r_cnt     <= n_cnt;
            r_is_stat <= (i_cmd.kind == K_STAT);
            r_stat    <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_vld <= !i_empty;
            r_idx <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

FILE: rtl/core/json_string_unescape.sv
// top level of the json string literal unescaper
// path: an accepted byte's command is written into the command queue, then loaded into the back end's output registers
// throughput: one byte per cycle while the queue is not full; a byte that yields several results holds the back end,
//   and the command queue of P_QDEPTH entries absorbs such bursts
// bytes that yield no result (backslash, hex digits, held high surrogate) push no command into the queue
// reset: synchronous active low, clears string state, queue and output valid
module json_string_unescape #(
    parameter int unsigned P_QDEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jsu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    t_cmd front_cmd, queue_cmd;
    logic push, full, pop, empty;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    jsu_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/core/jsu_checker.sv
// port checker for the json string unescaper and its bind
module jsu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input jsu_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    logic in_seen;
    assign in_seen = i_in_valid && o_in_ready && i_in.end_of_input;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output item changed while stalled");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_DATA |-> o_out.last)
        else $error("status item is not the last of its byte");

    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_DATA |-> o_out.out_byte == 8'd0)
        else $error("status item carries a data byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status == ST_DATA || o_out.status == ST_CLOSED ||
            o_out.status == ST_NO_QUOTE || o_out.status == ST_BAD_HEX ||
            o_out.status == ST_UNTERM)
        else $error("undefined status code");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_seen |-> !$isunknown(i_in.byte_in))
        else $error("unknown byte on final input item");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

FILE: verif/json_string_unescape_tb.sv
// testbench for json_string_unescape: random and directed string literals
module json_string_unescape_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    localparam logic [7:0]  CH_QUOTE    = 8'h22;
    localparam logic [7:0]  CH_BSLASH   = 8'h5C;
    localparam logic [7:0]  CH_U        = 8'h75;
    localparam int unsigned ITEM_TARGET = 430;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {M_IDLE, M_STR, M_ESC, M_HEX} t_str_mode;

    class unescape_scoreboard;
        t_out       pending_results[$];
        t_out       step_res[$];
        int         errors;
        t_str_mode  mode;
        logic [1:0] hex_cnt;
        logic [15:0] hex_acc;
        logic [9:0] held;
        logic       holding;

        function new();
            errors = 0;
            go_idle();
        endfunction

        function void go_idle();
            mode    = M_IDLE;
            hex_cnt = '0;
            hex_acc = '0;
            held    = '0;
            holding = 1'b0;
        endfunction

        function void push(logic [7:0] b, logic [2:0] st);
            t_out r;
            if (step_res.size() < 8) begin
                r.out_byte = b;
                r.status   = st;
                r.last     = 1'b0;
                step_res.push_back(r);
            end
        endfunction

        // an error voids whatever this item produced
        function void abort(logic [2:0] st);
            step_res.delete();
            push(8'h00, st);
            go_idle();
        endfunction

        function void utf8(logic [20:0] cp);
            if (cp < 21'h80) begin
                push(cp[7:0], ST_DATA);
            end else if (cp < 21'h800) begin
                push({3'b110, cp[10:6]}, ST_DATA);
                push({2'b10, cp[5:0]}, ST_DATA);
            end else if (cp < 21'h10000) begin
                push({4'b1110, cp[15:12]}, ST_DATA);
                push({2'b10, cp[11:6]}, ST_DATA);
                push({2'b10, cp[5:0]}, ST_DATA);
            end else begin
                push({5'b11110, cp[20:18]}, ST_DATA);
                push({2'b10, cp[17:12]}, ST_DATA);
                push({2'b10, cp[11:6]}, ST_DATA);
                push({2'b10, cp[5:0]}, ST_DATA);
            end
        endfunction

        function void flush_high();
            if (holding) begin
                utf8(21'hD800 + 21'(held));
                holding = 1'b0;
                held    = '0;
            end
        endfunction

        function void note_input(t_in it);
            logic [7:0]  b;
            logic [7:0]  e;
            logic        eoi;
            logic [3:0]  d;
            logic        ok;
            logic [20:0] pair;
            b   = it.byte_in;
            eoi = it.end_of_input;
            step_res.delete();
            case (mode)
                M_STR: begin
                    if (b == CH_QUOTE) begin
                        flush_high();
                        push(8'h00, ST_CLOSED);
                        go_idle();
                    end else if (b == CH_BSLASH) begin
                        mode = M_ESC;
                        if (eoi) abort(ST_UNTERM);
                    end else begin
                        flush_high();
                        push(b, ST_DATA);
                        if (eoi) abort(ST_UNTERM);
                    end
                end
                M_ESC: begin
                    if (b == CH_U) begin
                        mode    = M_HEX;
                        hex_cnt = '0;
                        hex_acc = '0;
                        if (eoi) abort(ST_BAD_HEX);
                    end else begin
                        flush_high();
                        case (b)
                            "n":     e = 8'h0A;
                            "t":     e = 8'h09;
                            "r":     e = 8'h0D;
                            "b":     e = 8'h08;
                            "f":     e = 8'h0C;
                            default: e = b;
                        endcase
                        push(e, ST_DATA);
                        mode = M_STR;
                        if (eoi) abort(ST_UNTERM);
                    end
                end
                M_HEX: begin
                    ok = 1'b1;
                    d  = '0;
                    if (b inside {["0":"9"]}) begin
                        d = 4'(b - "0");
                    end else if (b inside {["a":"f"]}) begin
                        d = 4'(b - "a" + 8'd10);
                    end else if (b inside {["A":"F"]}) begin
                        d = 4'(b - "A" + 8'd10);
                    end else begin
                        ok = 1'b0;
                    end
                    if (!ok) begin
                        abort(ST_BAD_HEX);
                    end else begin
                        hex_acc = {hex_acc[11:0], d};
                        if (hex_cnt == 2'd3) begin
                            hex_cnt = '0;
                            mode    = M_STR;
                            if (holding && hex_acc inside {[16'hDC00:16'hDFFF]}) begin
                                pair = 21'h10000 + (21'(held) << 10) + 21'(hex_acc - 16'hDC00);
                                utf8(pair);
                                holding = 1'b0;
                                held    = '0;
                            end else begin
                                flush_high();
                                if (hex_acc inside {[16'hD800:16'hDBFF]}) begin
                                    held    = hex_acc[9:0];
                                    holding = 1'b1;
                                end else begin
                                    utf8({5'b0, hex_acc});
                                end
                            end
                            hex_acc = '0;
                            if (eoi) abort(ST_UNTERM);
                        end else begin
                            hex_cnt++;
                            if (eoi) abort(ST_BAD_HEX);
                        end
                    end
                end
                default: begin
                    if (b != CH_QUOTE) begin
                        abort(ST_NO_QUOTE);
                    end else if (eoi) begin
                        abort(ST_UNTERM);
                    end else begin
                        go_idle();
                        mode = M_STR;
                    end
                end
            endcase
            if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
            foreach (step_res[i]) pending_results.push_back(step_res[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(t_out got);
            t_out exp;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected item byte %h status %0d last %0b",
                                 got.out_byte, got.status, got.last));
            end else begin
                exp = pending_results.pop_front();
                if (got.out_byte !== exp.out_byte)
                    report($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
                if (got.status !== exp.status)
                    report($sformatf("status %0d, expected %0d", got.status, exp.status));
                if (got.last !== exp.last)
                    report($sformatf("last %0b, expected %0b", got.last, exp.last));
            end
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_item   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_out        out_item;

    unescape_scoreboard sb;
    t_in         str_q[$];
    int          n_sent = 0;
    bit          calm   = 1'b0;
    int unsigned cycles = 0;

    json_string_unescape dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void add(logic [7:0] b);
        t_in it;
        it.byte_in      = b;
        it.end_of_input = 1'b0;
        str_q.push_back(it);
    endfunction

    function automatic void mark_end();
        str_q[str_q.size() - 1].end_of_input = 1'b1;
    endfunction

    // backslash-u escape, hex letters in random case
    function automatic void add_uesc(logic [15:0] v);
        logic [3:0] nib;
        add(CH_BSLASH);
        add(CH_U);
        for (int i = 3; i >= 0; i--) begin
            nib = v[4*i +: 4];
            if (nib < 4'd10) add(8'("0" + nib));
            else add(8'(($urandom_range(0, 1) ? "a" : "A") + nib - 4'd10));
        end
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    function automatic void build_string();
        int         r;
        int         cut;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            add(b);
            if ($urandom_range(0, 1)) mark_end();
        end else if (r < 10) begin
            add(CH_QUOTE);
            mark_end();
        end else begin
            add(CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        add(b);
                    end
                    3: begin
                        add(CH_BSLASH);
                        case ($urandom_range(0, 9))
                            0: add("n");
                            1: add("t");
                            2: add("r");
                            3: add("b");
                            4: add("f");
                            5: add(CH_QUOTE);
                            6: add(CH_BSLASH);
                            7: add("/");
                            default: begin
                                do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                                add(b);
                            end
                        endcase
                    end
                    4: add_uesc(16'($urandom_range(0, 65535)));
                    5: begin
                        add_uesc(rand_high());
                        add_uesc(rand_low());
                    end
                    6: add_uesc(rand_high());
                    7: add_uesc(rand_low());
                    8: add_uesc(16'($urandom_range(0, 16'h07FF)));
                    default: begin
                        add_uesc(rand_high());
                        add_uesc(16'($urandom_range(0, 65535)));
                    end
                endcase
            end
            if (r < 22) begin
                // broken hex, sometimes while a high surrogate waits
                if ($urandom_range(0, 1)) add_uesc(rand_high());
                add(CH_BSLASH);
                add(CH_U);
                repeat ($urandom_range(0, 3)) add(8'("0" + $urandom_range(0, 9)));
                do b = 8'($urandom_range(0, 255));
                while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                add(b);
                if ($urandom_range(0, 3) == 0) mark_end();
            end else if (r < 36) begin
                cut = $urandom_range(1, str_q.size());
                while (str_q.size() > cut) void'(str_q.pop_back());
                mark_end();
            end else begin
                add(CH_QUOTE);
                if ($urandom_range(0, 3) == 0) mark_end();
            end
        end
    endfunction

    task automatic send_item(t_in it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic send_all();
        foreach (str_q[i]) send_item(str_q[i]);
        str_q.delete();
    endtask

    initial begin
        int gap;
        int n_rx;
        bit long_done;
        n_rx      = 0;
        long_done = 1'b0;
        wait (rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 9);
            // long hold-off so the block fills up and stalls its input
            if (!long_done && n_rx == 60) begin
                long_done = 1'b1;
                gap       = 150;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            sb.check_result(out_item);
            n_rx++;
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no opening quote, then a quote that ends the input
        add("x");
        add(CH_QUOTE);
        mark_end();
        // byte extremes and a simple escape
        add(CH_QUOTE);
        add(8'h00);
        add(8'hFF);
        add(CH_BSLASH);
        add("n");
        add(CH_QUOTE);
        // highest high surrogate paired with the lowest low surrogate
        add(CH_QUOTE);
        add_uesc(16'hDBFF);
        add_uesc(16'hDC00);
        add(CH_QUOTE);
        // input ends right after backslash-u
        add(CH_QUOTE);
        add(CH_BSLASH);
        add(CH_U);
        mark_end();
        send_all();

        while (n_sent < ITEM_TARGET) begin
            calm = (n_sent >= 150 && n_sent < 230);
            build_string();
            send_all();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
